// File: rtl/mexp_pkg.sv
// shared constants and state type for the modular exponentiation block
`default_nettype none

package mexp_pkg;

	localparam int MEXP_MOD_WIDTH = 32;
	localparam int MEXP_EXP_WIDTH = 32;
	localparam int MEXP_DATA_WIDTH = 32;
	localparam logic [63:0] MEXP_MOD_RESET = 64'd2147483647;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE_GO,
		ST_REDUCE,
		ST_STEP_GO,
		ST_STEP,
		ST_FINISH
	} mexp_state_t;

endpackage

`default_nettype wire

// File: rtl/mexp_modmul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`default_nettype none

module mexp_modmul #(
	parameter int MOD_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [MOD_WIDTH-1:0] mcand,
	input  wire logic [MOD_WIDTH-1:0] mplier,
	input  wire logic [MOD_WIDTH-1:0] modulus,
	output logic                      done,
	output logic [MOD_WIDTH-1:0]      product
);

	localparam int CNT_W = $clog2(MOD_WIDTH + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] mplier_q;

	logic [MOD_WIDTH:0]   dbl;
	logic [MOD_WIDTH:0]   dbl_red;
	logic [MOD_WIDTH:0]   sum;
	logic [MOD_WIDTH:0]   sum_red;
	logic [MOD_WIDTH-1:0] acc_next;

	// acc stays below modulus, so each reduction needs one conditional subtract
	// the caller must hold mcand and modulus steady while busy; this block does not enforce it
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
		sum = dbl_red + {1'b0, mcand};
		sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
		acc_next = mplier_q[MOD_WIDTH-1] ? sum_red[MOD_WIDTH-1:0] : dbl_red[MOD_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MOD_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mplier_q <= mplier;
		end else if (busy_q) begin
			acc_q <= acc_next;
			mplier_q <= {mplier_q[MOD_WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation_top.sv
// modular exponentiation top level: right-to-left square and multiply
// steps: base reduction (ST_REDUCE_GO, ST_REDUCE), then one square and multiply step per exponent
// bit up to the highest set bit (ST_STEP_GO, ST_STEP), then ST_FINISH registers the result
// one request at a time: the next is taken in ST_IDLE, after the result is registered; multiply
// and square run side by side in two units
// arst_n clears control state and loads the modulus register with 2^31-1 (masked to MOD_WIDTH)
`default_nettype none

module modular_exponentiation_top #(
	parameter int MOD_WIDTH = mexp_pkg::MEXP_MOD_WIDTH,
	parameter int EXP_WIDTH = mexp_pkg::MEXP_EXP_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 modulus_we,
	input  wire logic [MOD_WIDTH-1:0] modulus_wdata,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [63:0]          s_axis_tdata,   // base_value [31:0], exponent [63:32]
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [31:0]               m_axis_tdata    // power_result [31:0]
);

	import mexp_pkg::*;

	mexp_state_t state_q, state_d;

	logic [MOD_WIDTH-1:0] modulus_q;
	logic [MOD_WIDTH-1:0] base_q;
	logic [MOD_WIDTH-1:0] res_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic                 out_valid_q;
	logic [31:0]          out_data_q;

	logic                 accept;
	logic                 out_load;
	logic [MOD_WIDTH-1:0] one_mod;
	logic                 mod_zero;
	logic [MOD_WIDTH+31:0] base_ext;
	logic [EXP_WIDTH+31:0] exp_ext;
	logic [MOD_WIDTH+31:0] res_ext;
	logic [EXP_WIDTH-1:0] exp_shr;

	logic                 sq_start, res_start;
	logic [MOD_WIDTH-1:0] sq_mcand, sq_mplier;
	logic                 sq_done, res_done;
	logic [MOD_WIDTH-1:0] sq_prod, res_prod;

	assign mod_zero = (modulus_q == '0);
	assign one_mod = {{(MOD_WIDTH-1){1'b0}}, (modulus_q != MOD_WIDTH'(1))};
	assign base_ext = {{MOD_WIDTH{1'b0}}, s_axis_tdata[31:0]};
	assign exp_ext = {{EXP_WIDTH{1'b0}}, s_axis_tdata[63:32]};
	assign res_ext = {32'd0, res_q};
	assign exp_shr = exp_q >> 1;

	assign accept = s_axis_tvalid && s_axis_tready;

	// base reduction reuses the squaring unit as (1 mod m) * base
	assign sq_mcand = (state_q == ST_REDUCE_GO || state_q == ST_REDUCE) ? one_mod : base_q;
	assign sq_mplier = base_q;

	mexp_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_sq (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.mcand(sq_mcand), .mplier(sq_mplier), .modulus(modulus_q),
		.done(sq_done), .product(sq_prod)
	);

	mexp_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_res (
		.clk(clk), .arst_n(arst_n), .start(res_start),
		.mcand(res_q), .mplier(base_q), .modulus(modulus_q),
		.done(res_done), .product(res_prod)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = mod_zero ? ST_FINISH : ST_REDUCE_GO;
			end
			ST_REDUCE_GO: state_d = ST_REDUCE;
			ST_REDUCE: begin
				if (sq_done)
					state_d = (exp_q == '0) ? ST_FINISH : ST_STEP_GO;
			end
			ST_STEP_GO: state_d = ST_STEP;
			ST_STEP: begin
				if (sq_done)
					state_d = (exp_shr == '0) ? ST_FINISH : ST_STEP_GO;
			end
			ST_FINISH: begin
				if (!out_valid_q || m_axis_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		sq_start = 1'b0;
		res_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_REDUCE_GO: sq_start = 1'b1;
			ST_STEP_GO: begin
				sq_start = 1'b1;
				res_start = 1'b1;
			end
			ST_FINISH: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			modulus_q <= MEXP_MOD_RESET[MOD_WIDTH-1:0];
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (modulus_we)
				modulus_q <= modulus_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base_ext[MOD_WIDTH-1:0];
			exp_q <= exp_ext[EXP_WIDTH-1:0];
			res_q <= mod_zero ? '0 : one_mod;
		end
		if (state_q == ST_REDUCE && sq_done)
			base_q <= sq_prod;
		if (state_q == ST_STEP && sq_done) begin
			base_q <= sq_prod;
			exp_q <= exp_shr;
			if (exp_q[0])
				res_q <= res_prod;
		end
		if (out_load)
			out_data_q <= res_ext[31:0];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// the multiply unit only runs alongside the squaring unit
	a_res_with_sq: assert property (@(posedge clk) disable iff (!arst_n)
		res_done |-> sq_done)
		else $error("multiply unit finished without the squaring unit");

	// a step is only taken while exponent bits remain
	a_step_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (exp_q != '0))
		else $error("step with empty exponent");

	// the result is reduced below the modulus in ST_FINISH, unless the modulus is zero
	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (mod_zero || res_q < modulus_q))
		else $error("result not below modulus");

	// a result is registered only into a free or draining output slot
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready && state_q == ST_FINISH) |=> (state_q == ST_FINISH))
		else $error("result dropped while output stalled");

endmodule

`default_nettype wire
